/* src/usmf_pkg.sv */
// Package for the UART status message filter: state and operation codes,
// controller/datapath command and status structs, and the status word table.
// Depends on nothing; the controller, datapath, top level and testbench use it.
`default_nettype none

package usmf_pkg;

	// Byte that opens and closes a status message.
	localparam logic [7:0] MARK_BYTE = 8'h25;

	// Number of status words and the mask with all of them still matching.
	localparam int WORD_COUNT = 5;
	localparam logic [WORD_COUNT-1:0] ALL_ALIVE = 5'h1f;

	// Length of the longest status word, in characters.
	localparam int WORD_MAX_LEN = 12;

	// Status word text, packed right-aligned with the last character in the bottom byte.
	localparam logic [8*WORD_MAX_LEN-1:0] WORD0 = (8*WORD_MAX_LEN)'({"RFCOMM", "_CLOSE"});
	localparam logic [8*WORD_MAX_LEN-1:0] WORD1 = (8*WORD_MAX_LEN)'({"RFCOMM", "_OPEN"});
	localparam logic [8*WORD_MAX_LEN-1:0] WORD2 = "CONNECT";
	localparam logic [8*WORD_MAX_LEN-1:0] WORD3 = "DISCONN";
	localparam logic [8*WORD_MAX_LEN-1:0] WORD4 = "BONDED";

	// Controller states.
	typedef enum logic [1:0] {
		ST_ACCEPT,
		ST_READ,
		ST_LOAD
	} state_t;

	// Operations the controller asks of the datapath in one cycle.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_PASS,
		OP_OPEN,
		OP_CLOSE,
		OP_HOLD,
		OP_READ,
		OP_LOAD
	} op_t;

	// Commands from the controller.
	typedef struct packed {
		op_t  op;
		logic in_ready;
	} cmd_t;

	// Status from the datapath.
	typedef struct packed {
		logic count_zero;
		logic is_mark;
		logic full;
		logic mismatch;
		logic out_free;
		logic last_entry;
	} status_t;

	// Length of status word w.
	function automatic logic [3:0] word_len(input logic [2:0] w);
		logic [3:0] len;
		case (w)
			3'd0: len = 4'd12;
			3'd1: len = 4'd11;
			3'd2: len = 4'd7;
			3'd3: len = 4'd7;
			3'd4: len = 4'd6;
			default: len = 4'd0;
		endcase
		return len;
	endfunction

	// Character p of status word w; zero past the end of the word.
	function automatic logic [7:0] word_char(input logic [2:0] w, input logic [3:0] p);
		logic [8*WORD_MAX_LEN-1:0] text;
		logic [3:0]                len;
		logic [3:0]                sel;
		case (w)
			3'd0: text = WORD0;
			3'd1: text = WORD1;
			3'd2: text = WORD2;
			3'd3: text = WORD3;
			3'd4: text = WORD4;
			default: text = '0;
		endcase
		len = word_len(w);
		if (p >= len) begin
			return 8'h00;
		end
		sel = len - 4'd1 - p;
		return text[8*sel +: 8];
	endfunction

endpackage

`default_nettype wire

/* src/usmf_in_if.sv */
// Request channel carrying received bytes into the filter.
// Depends on nothing.
`default_nettype none

interface usmf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* src/usmf_out_if.sv */
// Request channel carrying filtered bytes out of the filter.
// Depends on nothing.
`default_nettype none

interface usmf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

/* src/usmf_ctrl.sv */
// Controller of the status message filter: decides per cycle what the
// datapath does and sequences the drain of a held run. Uses usmf_pkg.
`default_nettype none

module usmf_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire usmf_pkg::status_t status,
	output usmf_pkg::cmd_t        cmd
);
	import usmf_pkg::*;

	state_t state_q;
	state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands.
	always_comb begin
		state_next   = state_q;
		cmd.op       = OP_NONE;
		cmd.in_ready = 1'b0;
		case (state_q)
			ST_ACCEPT: begin
				cmd.in_ready = status.out_free;
				if (in_valid && status.out_free) begin
					if (status.count_zero) begin
						cmd.op = status.is_mark ? OP_OPEN : OP_PASS;
					end else if (status.is_mark) begin
						cmd.op = OP_CLOSE;
					end else if (status.full) begin
						// The arriving byte is dropped and the held run goes out.
						state_next = ST_READ;
					end else begin
						cmd.op = OP_HOLD;
						if (status.mismatch) begin
							state_next = ST_READ;
						end
					end
				end
			end
			ST_READ: begin
				cmd.op     = OP_READ;
				state_next = ST_LOAD;
			end
			ST_LOAD: begin
				if (status.out_free) begin
					cmd.op     = OP_LOAD;
					state_next = status.last_entry ? ST_ACCEPT : ST_READ;
				end
			end
			default: begin
				state_next = ST_ACCEPT;
			end
		endcase
	end

endmodule

`default_nettype wire

/* src/usmf_datapath.sv */
// Datapath of the status message filter: message buffer memory, fill count,
// word match mask, drain index and output register. Uses usmf_pkg.
`default_nettype none

module usmf_datapath #(
	parameter int BUF_DEPTH = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [7:0]        rx_byte,
	input  wire usmf_pkg::cmd_t    cmd,
	output usmf_pkg::status_t      status,
	usmf_out_if.source             tx
);
	import usmf_pkg::*;

	localparam int IDX_W = $clog2(BUF_DEPTH);
	localparam int CNT_W = $clog2(BUF_DEPTH + 1);

	logic [7:0]            mem_q [BUF_DEPTH];
	logic [7:0]            rd_data_q;
	logic [CNT_W-1:0]      count_q;
	logic [IDX_W-1:0]      rd_idx_q;
	logic [WORD_COUNT-1:0] alive_q;
	logic [WORD_COUNT-1:0] alive_next;
	logic [CNT_W-1:0]      pos;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  out_last_q;
	logic                  load_out;

	// Offset of the arriving byte within the text after the opening mark.
	assign pos = count_q - CNT_W'(1);

	// Drop every word whose character at this offset differs from the byte.
	always_comb begin
		alive_next = alive_q;
		for (int i = 0; i < WORD_COUNT; i++) begin
			if (pos < CNT_W'(WORD_MAX_LEN)
			    && pos[3:0] < word_len(3'(i))
			    && word_char(3'(i), pos[3:0]) != rx_byte) begin
				alive_next[i] = 1'b0;
			end
		end
	end

	// Status toward the controller.
	assign status.count_zero = (count_q == '0);
	assign status.is_mark    = (rx_byte == MARK_BYTE);
	assign status.full       = (count_q == CNT_W'(BUF_DEPTH));
	assign status.mismatch   = (alive_next == '0);
	assign status.out_free   = !out_valid_q || tx.ready;
	assign status.last_entry = ((CNT_W'(rd_idx_q) + CNT_W'(1)) == count_q);

	// Message buffer: written while a message is held, read during a drain.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_OPEN: mem_q[0] <= rx_byte;
			OP_HOLD: mem_q[count_q[IDX_W-1:0]] <= rx_byte;
			OP_READ: rd_data_q <= mem_q[rd_idx_q];
			default: ;
		endcase
	end

	// Fill count, match mask and drain index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			alive_q  <= ALL_ALIVE;
			rd_idx_q <= '0;
		end else begin
			case (cmd.op)
				OP_OPEN: begin
					count_q <= CNT_W'(1);
					alive_q <= ALL_ALIVE;
				end
				OP_CLOSE: begin
					count_q <= '0;
					alive_q <= ALL_ALIVE;
				end
				OP_HOLD: begin
					count_q <= count_q + CNT_W'(1);
					alive_q <= alive_next;
				end
				OP_LOAD: begin
					if (status.last_entry) begin
						count_q  <= '0;
						alive_q  <= ALL_ALIVE;
						rd_idx_q <= '0;
					end else begin
						rd_idx_q <= rd_idx_q + IDX_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	assign load_out = (cmd.op == OP_PASS) || (cmd.op == OP_LOAD);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_PASS) begin
			out_byte_q <= rx_byte;
			out_last_q <= 1'b1;
		end else if (cmd.op == OP_LOAD) begin
			out_byte_q <= rd_data_q;
			out_last_q <= status.last_entry;
		end
	end

	assign tx.valid    = out_valid_q;
	assign tx.out_byte = out_byte_q;
	assign tx.last     = out_last_q;

endmodule

`default_nettype wire

/* src/uart_status_message_filter_core.sv */
// Top level of the UART status message filter: joins controller and datapath.
// Depends on usmf_pkg, usmf_in_if, usmf_out_if, usmf_ctrl and usmf_datapath.
//
//   channel | direction | payload          | handshake
//   rx      | in        | rx_byte[7:0]     | valid / ready
//   tx      | out       | out_byte[7:0]    | valid / ready, last marks run end
//
// A pass-through, opening, closing or held byte is accepted directly in ST_ACCEPT.
// A run of held bytes drains byte by byte: each byte takes a registered buffer
// read and then a load of the output register, which waits while it is full.
// No input is accepted while a run drains or while the output register is full.
// Reset clears the fill count, the match mask and the output valid; the buffer
// contents are not cleared, so no clearing pass follows reset.
`default_nettype none

module uart_status_message_filter_core #(
	parameter int BUF_DEPTH = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	usmf_in_if.sink    rx,
	usmf_out_if.source tx
);
	import usmf_pkg::*;

	cmd_t    cmd;
	status_t status;

	usmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.status   (status),
		.cmd      (cmd)
	);

	usmf_datapath #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_byte (rx.rx_byte),
		.cmd     (cmd),
		.status  (status),
		.tx      (tx)
	);

	assign rx.ready = cmd.in_ready;

endmodule

`default_nettype wire

/* src/usmf_checker.sv */
// Port-level checks for the UART status message filter, bound to the top level.
// Depends on uart_status_message_filter_core.
`default_nettype none

module usmf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rx_valid,
	input wire logic       rx_ready,
	input wire logic       tx_valid,
	input wire logic       tx_ready,
	input wire logic [7:0] tx_out_byte,
	input wire logic       tx_last
);

	// A stalled result stays offered.
	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid)
		else $error("tx valid dropped while stalled");

	// A stalled result keeps its payload.
	a_tx_stable: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> $stable(tx_out_byte) && $stable(tx_last))
		else $error("tx payload changed while stalled");

	// Input is only taken when the output register has room.
	a_rx_room: assert property (@(posedge clk) disable iff (!arst_n)
		rx_ready |-> !tx_valid || tx_ready)
		else $error("rx ready while output register is blocked");

	// While a byte from the middle of a run is offered, no new input is taken.
	a_run_blocks_rx: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_last |-> !rx_ready)
		else $error("rx ready during a run drain");

	// A request is only taken while the output register can take a result.
	a_rx_accept_room: assert property (@(posedge clk) disable iff (!arst_n)
		rx_valid && rx_ready |-> !tx_valid || tx_ready)
		else $error("request accepted while output register is blocked");

endmodule

bind uart_status_message_filter_core usmf_checker u_usmf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rx_valid    (rx.valid),
	.rx_ready    (rx.ready),
	.tx_valid    (tx.valid),
	.tx_ready    (tx.ready),
	.tx_out_byte (tx.out_byte),
	.tx_last     (tx.last)
);

`default_nettype wire

/* dv/uart_status_message_filter_core_tb.sv */
// Testbench for uart_status_message_filter_core: random and directed byte streams,
// predicted byte by byte and checked at the output channel.
// Depends on usmf_pkg, usmf_in_if, usmf_out_if and the filter RTL.
`timescale 1ns / 1ps

module uart_status_message_filter_core_tb;

	localparam int MSG_DEPTH   = 64;
	localparam int N_WORDS     = 5;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 200;
	localparam int RANDOM_FILL = 320;
	localparam int MAX_PRINTS  = 20;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} filtered_byte_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Registered stimulus, known from time zero.
	logic       in_valid  = 1'b0;
	logic [7:0] in_byte   = 8'h00;
	logic       out_ready = 1'b0;

	usmf_in_if  rx_chan ();
	usmf_out_if tx_chan ();

	assign rx_chan.valid   = in_valid;
	assign rx_chan.rx_byte = in_byte;
	assign tx_chan.ready   = out_ready;

	uart_status_message_filter_core #(
		.BUF_DEPTH(MSG_DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_chan),
		.tx    (tx_chan)
	);

	// Status words that hold a message open while they still match.
	string status_words [N_WORDS];

	// Predictor state: the open message and the words it still matches.
	logic [7:0]         msg_buf [MSG_DEPTH];
	int                 msg_len;
	logic [N_WORDS-1:0] words_alive;

	logic [7:0]     pending_bytes [$];
	filtered_byte_t expected_out [$];
	filtered_byte_t next_expected;
	int             total_bytes;
	int             bytes_sent;
	int             mismatches;
	int             idle_cycles;
	logic           steady;

	// No idling on either side over a stretch in the middle of the run.
	assign steady = (bytes_sent >= 120) && (bytes_sent < 200);

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_PRINTS) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
		mismatches++;
	endtask

	// Send out the whole held message as one run and close it.
	task automatic flush_message();
		filtered_byte_t beat;
		for (int k = 0; k < msg_len; k++) begin
			beat.data = msg_buf[k];
			beat.last = (k == msg_len - 1);
			expected_out.push_back(beat);
		end
		msg_len = 0;
		words_alive = usmf_pkg::ALL_ALIVE;
	endtask

	// Work out the results of one accepted byte.
	task automatic filter_byte(input logic [7:0] b);
		filtered_byte_t beat;
		string          word;
		int             pos;
		if (msg_len == 0) begin
			if (b == usmf_pkg::MARK_BYTE) begin
				msg_buf[0] = b;
				msg_len = 1;
				words_alive = usmf_pkg::ALL_ALIVE;
			end else begin
				beat.data = b;
				beat.last = 1'b1;
				expected_out.push_back(beat);
			end
		end else if (b == usmf_pkg::MARK_BYTE) begin
			msg_len = 0;
			words_alive = usmf_pkg::ALL_ALIVE;
		end else if (msg_len >= MSG_DEPTH) begin
			// Full buffer: the new byte is dropped.
			flush_message();
		end else begin
			msg_buf[msg_len] = b;
			msg_len++;
			pos = msg_len - 2;
			for (int w = 0; w < N_WORDS; w++) begin
				word = status_words[w];
				if (pos < word.len() && word[pos] != b) begin
					words_alive[w] = 1'b0;
				end
			end
			if (words_alive == '0) begin
				flush_message();
			end
		end
	endtask

	// Any byte but the mark, uniform over the other 255 values.
	function automatic logic [7:0] rand_plain();
		logic [8:0] v;
		v = 9'($urandom_range(0, 254));
		if (v >= usmf_pkg::MARK_BYTE) begin
			v++;
		end
		return v[7:0];
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			pending_bytes.push_back(s[i]);
		end
	endtask

	// A message opening with part or all of a status word, then a random ending.
	task automatic add_message();
		string word;
		int    plen;
		word = status_words[$urandom_range(0, N_WORDS - 1)];
		plen = $urandom_range(0, word.len());
		pending_bytes.push_back(usmf_pkg::MARK_BYTE);
		for (int i = 0; i < plen; i++) begin
			pending_bytes.push_back(word[i]);
		end
		case ($urandom_range(0, 3))
			0: begin
				pending_bytes.push_back(usmf_pkg::MARK_BYTE);
			end
			1: begin
				pending_bytes.push_back(rand_plain());
			end
			2: begin
				repeat ($urandom_range(1, 6)) pending_bytes.push_back(rand_plain());
				pending_bytes.push_back(usmf_pkg::MARK_BYTE);
			end
			default: begin
			end
		endcase
	endtask

	// A full word and filler up to a full buffer, then one more byte.
	task automatic add_overflow();
		string word;
		word = status_words[$urandom_range(0, N_WORDS - 1)];
		pending_bytes.push_back(usmf_pkg::MARK_BYTE);
		push_text(word);
		repeat (MSG_DEPTH - 1 - word.len()) pending_bytes.push_back(rand_plain());
		if ($urandom_range(0, 3) == 0) begin
			pending_bytes.push_back(usmf_pkg::MARK_BYTE);
		end else begin
			pending_bytes.push_back(rand_plain());
		end
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	// Stimulus, reset and end of run.
	initial begin
		int         overflows;
		logic [7:0] noise;
		string      stem;
		stem = "RFCOMM";
		status_words[0] = {stem, "_CLOSE"};
		status_words[1] = {stem, "_OPEN"};
		status_words[2] = "CONNECT";
		status_words[3] = "DISCONN";
		status_words[4] = "BONDED";
		msg_len = 0;
		words_alive = usmf_pkg::ALL_ALIVE;
		mismatches = 0;
		overflows = 0;

		// Directed: byte extremes, close, mismatches at several depths, empty message.
		pending_bytes.push_back(8'h00);
		pending_bytes.push_back(8'hff);
		pending_bytes.push_back(8'h7e);
		push_text("%BONDED%");
		push_text("%CX");
		push_text("%Z");
		push_text("%%");
		push_text("%RFCOMM_Q");

		// Random: mostly well-formed messages, some noise, a few full buffers.
		add_overflow();
		overflows = 1;
		while (pending_bytes.size() < RANDOM_FILL) begin
			if ($urandom_range(0, 99) < 25) begin
				noise = 8'($urandom_range(0, 255));
				pending_bytes.push_back(noise);
			end else if ($urandom_range(0, 99) < 4 && overflows < 3) begin
				add_overflow();
				overflows++;
			end else begin
				add_message();
			end
		end
		total_bytes = pending_bytes.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_sent < total_bytes) @(posedge clk);
		while (expected_out.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_out.size() == 0) begin
			$display("PASS uart_status_message_filter_core");
		end else begin
			if (expected_out.size() != 0) begin
				report_mismatch($sformatf("%0d results never arrived", expected_out.size()));
			end
			$display("FAIL uart_status_message_filter_core");
		end
		$finish;
	end

	// Driver: presents the next pending request and predicts each accepted one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			in_byte    <= 8'h00;
			bytes_sent <= 0;
		end else if (!in_valid || rx_chan.ready) begin
			if (in_valid) begin
				filter_byte(in_byte);
				bytes_sent <= bytes_sent + 1;
			end
			if (pending_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= 29)) begin
				in_valid <= 1'b1;
				in_byte  <= pending_bytes.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks each accepted output byte against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (tx_chan.valid && tx_chan.ready) begin
				if (expected_out.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h last %0b",
						tx_chan.out_byte, tx_chan.last));
				end else begin
					next_expected = expected_out.pop_front();
					if (tx_chan.out_byte !== next_expected.data) begin
						report_mismatch($sformatf("out_byte %02h, predicted %02h",
							tx_chan.out_byte, next_expected.data));
					end
					if (tx_chan.last !== next_expected.last) begin
						report_mismatch($sformatf("last %0b, predicted %0b on byte %02h",
							tx_chan.last, next_expected.last, next_expected.data));
					end
				end
			end
			out_ready <= steady || ($urandom_range(0, 99) >= 29);
		end
	end

	// Watchdog: ends the run when no request moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((rx_chan.valid && rx_chan.ready) || (tx_chan.valid && tx_chan.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("[%0t] no request accepted for %0d cycles", $time, STALL_LIMIT);
			$display("FAIL uart_status_message_filter_core");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

/* sim.f */
src/usmf_pkg.sv
src/usmf_in_if.sv
src/usmf_out_if.sv
src/usmf_ctrl.sv
src/usmf_datapath.sv
src/uart_status_message_filter_core.sv
src/usmf_checker.sv
dv/uart_status_message_filter_core_tb.sv
